### hdl/scpr_pkg.sv
// scpr_pkg: shared constants and types for the second-chance page replacement block
// no dependencies; used by scpr_frame_store and second_chance_page_replacement_top
`timescale 1ns / 1ps

package scpr_pkg;

    // built sizes and field widths
    localparam int MAX_FRAMES_DEF = 64;
    localparam int PAGE_BITS_DEF  = 16;
    localparam int CFG_W          = 7;
    localparam int PAGE_IO_W      = 16;
    localparam int FRAME_OUT_W    = 6;
    localparam int TOTAL_W        = 32;
    localparam int S_TDATA_W      = 24;
    localparam int M_TDATA_W      = 96;

    // frames_in_use after reset
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 7'd64;

    // commands from the sequencer to the frame store
    typedef struct packed {
        logic load;       // new page, reference set, dirty from input
        logic touch;      // hit: reference set, dirty ored with input
        logic clear_ref;  // sweep: reference cleared
    } scpr_cmd_t;

endpackage

### hdl/scpr_frame_store.sv
// scpr_frame_store: page number memory plus reference and dirty bits per frame
// depends on scpr_pkg for the command struct
`timescale 1ns / 1ps

module scpr_frame_store
    import scpr_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    parameter int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scpr_cmd_t            cmd,
    input  logic [IDX_W-1:0]     idx,
    input  logic [IDX_W-1:0]     rd_idx,
    input  logic [PAGE_BITS-1:0] page_in,
    input  logic                 dirty_in,
    output logic [PAGE_BITS-1:0] rd_page,
    output logic                 ref_bit,
    output logic                 dirty_bit
);

    logic [PAGE_BITS-1:0]  page_mem [MAX_FRAMES];
    logic [PAGE_BITS-1:0]  rd_page_reg;
    logic [MAX_FRAMES-1:0] ref_reg;
    logic [MAX_FRAMES-1:0] dirty_reg;

    // page memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            page_mem[idx] <= page_in;
        end
        rd_page_reg <= page_mem[rd_idx];
    end

    // per-frame status bits, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg   <= '0;
            dirty_reg <= '0;
        end else begin
            if (cmd.load) begin
                ref_reg[idx]   <= 1'b1;
                dirty_reg[idx] <= dirty_in;
            end else if (cmd.touch) begin
                ref_reg[idx]   <= 1'b1;
                dirty_reg[idx] <= dirty_reg[idx] | dirty_in;
            end else if (cmd.clear_ref) begin
                ref_reg[idx]   <= 1'b0;
            end
        end
    end

    assign rd_page   = rd_page_reg;
    assign ref_bit   = ref_reg[idx];
    assign dirty_bit = dirty_reg[idx];

endmodule

### hdl/second_chance_page_replacement_top.sv
// second_chance_page_replacement_top: clock page replacement over a frame table
// a hit ends a linear search of the filled frames; a miss with the table full adds a sweep
// that clears set reference bits, then one victim read and replacement
// throughput: one item at a time, as s_tready is high only in the idle state
// reset: aresetn low clears the table status, hand, fill count, counters; frames_in_use = 64
// depends on scpr_pkg and scpr_frame_store
`timescale 1ns / 1ps

module second_chance_page_replacement_top
    import scpr_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write: frames_in_use
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // page[15:0], write_access[16], zero pad
    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // fault, evicted, victim_page[16], write_back,
                                           // frame[6], fault_total[32], write_back_total[32]
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FRAMES);
    localparam int PAD_W = M_TDATA_W - (4 + PAGE_IO_W + FRAME_OUT_W + 2 * TOTAL_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SWEEP,
        S_VICTIM,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       fiu_reg, fiu_next;
    logic [PAGE_BITS-1:0]   pg_reg, pg_next;
    logic                   wr_reg, wr_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic [CNT_W-1:0]       filled_reg, filled_next;
    logic [IDX_W-1:0]       hand_reg, hand_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [TOTAL_W-1:0]     fault_cnt_reg, fault_cnt_next;
    logic [TOTAL_W-1:0]     wb_cnt_reg, wb_cnt_next;
    logic                   res_fault_reg, res_fault_next;
    logic                   res_evicted_reg, res_evicted_next;
    logic [PAGE_IO_W-1:0]   res_victim_reg, res_victim_next;
    logic                   res_wb_reg, res_wb_next;
    logic [FRAME_OUT_W-1:0] res_frame_reg, res_frame_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    scpr_cmd_t              cmd;
    logic [IDX_W-1:0]       fs_idx;
    logic [IDX_W-1:0]       rd_idx;
    logic [PAGE_BITS-1:0]   rd_page;
    logic                   ref_bit;
    logic                   dirty_bit;

    logic [CMP_W-1:0]       fiu_ext;
    logic [CMP_W-1:0]       n_clamp;
    logic [CNT_W-1:0]       n_comb;
    logic [CNT_W-1:0]       hand_plus;
    logic [IDX_W-1:0]       hand_adv;

    scpr_frame_store #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .idx       (fs_idx),
        .rd_idx    (rd_idx),
        .page_in   (pg_reg),
        .dirty_in  (wr_reg),
        .rd_page   (rd_page),
        .ref_bit   (ref_bit),
        .dirty_bit (dirty_bit)
    );

    // effective frame count: zero acts as one, capped at the built size
    always_comb begin
        fiu_ext = CMP_W'(fiu_reg);
        if (fiu_ext == '0) begin
            n_clamp = CMP_W'(1);
        end else if (fiu_ext > MAX_CMP) begin
            n_clamp = MAX_CMP;
        end else begin
            n_clamp = fiu_ext;
        end
        n_comb = CNT_W'(n_clamp);
    end

    // clock hand advance with wrap at the frame count
    assign hand_plus = CNT_W'(hand_reg) + CNT_W'(1);
    assign hand_adv  = (hand_plus >= n_reg) ? '0 : hand_plus[IDX_W-1:0];

    // sequencer next state
    always_comb begin
        state_next       = state_reg;
        fiu_next         = fiu_reg;
        pg_next          = pg_reg;
        wr_next          = wr_reg;
        n_next           = n_reg;
        filled_next      = filled_reg;
        hand_next        = hand_reg;
        idx_next         = idx_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_idx_next     = cmp_idx_reg;
        fault_cnt_next   = fault_cnt_reg;
        wb_cnt_next      = wb_cnt_reg;
        res_fault_next   = res_fault_reg;
        res_evicted_next = res_evicted_reg;
        res_victim_next  = res_victim_reg;
        res_wb_next      = res_wb_reg;
        res_frame_next   = res_frame_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        cmd              = '0;
        fs_idx           = hand_reg;
        rd_idx           = hand_reg;

        // configuration transfer
        if (cfg_valid) begin
            fiu_next = cfg_data;
        end

        // result transfer frees the output register
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    pg_next        = PAGE_BITS'(s_tdata[PAGE_IO_W-1:0]);
                    wr_next        = s_tdata[PAGE_IO_W];
                    n_next         = n_comb;
                    filled_next    = (filled_reg > n_comb) ? n_comb : filled_reg;
                    idx_next       = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = S_LOOKUP;
                end
            end

            // linear search: read one frame per cycle, compare its page in the next cycle
            S_LOOKUP: begin
                rd_idx = idx_reg[IDX_W-1:0];
                if (cmp_valid_reg && (rd_page == pg_reg)) begin
                    cmd.touch        = 1'b1;
                    fs_idx           = cmp_idx_reg;
                    res_fault_next   = 1'b0;
                    res_evicted_next = 1'b0;
                    res_victim_next  = '0;
                    res_wb_next      = 1'b0;
                    res_frame_next   = FRAME_OUT_W'(cmp_idx_reg);
                    state_next       = S_DONE;
                end else if (idx_reg < filled_reg) begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg[IDX_W-1:0];
                    idx_next       = idx_reg + CNT_W'(1);
                end else begin
                    // miss
                    fault_cnt_next   = (fault_cnt_reg == '1) ? fault_cnt_reg
                                                             : fault_cnt_reg + 1'b1;
                    res_fault_next   = 1'b1;
                    res_evicted_next = 1'b0;
                    res_victim_next  = '0;
                    res_wb_next      = 1'b0;
                    if (filled_reg < n_reg) begin
                        cmd.load       = 1'b1;
                        fs_idx         = filled_reg[IDX_W-1:0];
                        filled_next    = filled_reg + CNT_W'(1);
                        res_frame_next = FRAME_OUT_W'(filled_reg);
                        state_next     = S_DONE;
                    end else begin
                        if (CNT_W'(hand_reg) >= n_reg) begin
                            hand_next = '0;
                        end
                        state_next = S_SWEEP;
                    end
                end
            end

            // second chance: clear referenced frames until an unreferenced one
            S_SWEEP: begin
                if (ref_bit) begin
                    cmd.clear_ref = 1'b1;
                    hand_next     = hand_adv;
                end else begin
                    state_next = S_VICTIM;
                end
            end

            // victim page read back, replace it
            S_VICTIM: begin
                cmd.load         = 1'b1;
                res_evicted_next = 1'b1;
                res_victim_next  = PAGE_IO_W'(rd_page);
                res_wb_next      = dirty_bit;
                res_frame_next   = FRAME_OUT_W'(hand_reg);
                if (dirty_bit) begin
                    wb_cnt_next = (wb_cnt_reg == '1) ? wb_cnt_reg : wb_cnt_reg + 1'b1;
                end
                hand_next  = hand_adv;
                state_next = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}}, wb_cnt_reg, fault_cnt_reg,
                                     res_frame_reg, res_wb_reg, res_victim_reg,
                                     res_evicted_reg, res_fault_reg};
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fiu_reg       <= FRAMES_IN_USE_RST;
            filled_reg    <= '0;
            hand_reg      <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            fault_cnt_reg <= '0;
            wb_cnt_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fiu_reg       <= fiu_next;
            filled_reg    <= filled_next;
            hand_reg      <= hand_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            fault_cnt_reg <= fault_cnt_next;
            wb_cnt_reg    <= wb_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pg_reg          <= pg_next;
        wr_reg          <= wr_next;
        n_reg           <= n_next;
        cmp_idx_reg     <= cmp_idx_next;
        res_fault_reg   <= res_fault_next;
        res_evicted_reg <= res_evicted_next;
        res_victim_reg  <= res_victim_next;
        res_wb_reg      <= res_wb_next;
        res_frame_reg   <= res_frame_next;
        m_tdata_reg     <= m_tdata_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

endmodule
